>>> design/triangle_unit_normal_defines.svh
// Assertion helpers for the triangle normal unit.
// Both sample on clk and are disabled while rst_n is low.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Consequent checked at the same edge.
`define TUN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked at the next edge.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tun_pkg.sv
`default_nettype none
package tun_pkg;

  localparam int COORD_W = 16;            // vertex coordinate width
  localparam int EW      = COORD_W + 1;   // edge vector component
  localparam int PW      = 2 * EW;        // edge product
  localparam int NW      = PW + 1;        // cross product component, signed
  localparam int MW      = PW;            // cross product magnitude
  localparam int HW      = MW / 2;        // half of magnitude for split square
  localparam int SQW     = 2 * MW;        // square of magnitude
  localparam int SW      = SQW + 2;       // sum of three squares
  localparam int OW      = 16;            // output component width

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [OW-1:0] norm_x;
    logic signed [OW-1:0] norm_y;
    logic signed [OW-1:0] norm_z;
    logic                 degenerate;
  } tun_out_t;

  // Width of the residual and partial product words in the root steps.
  function automatic int tun_dw(input int frac);
    return 2 * MW + 2 * frac + 8;
  endfunction

  // Width of the word carried between root steps: three lanes, sum, zero flag.
  function automatic int tun_iw(input int frac);
    return 3 * (2 * tun_dw(frac) + frac + 2) + SW + 1;
  endfunction

endpackage
`default_nettype wire

>>> design/tun_front.sv
`default_nettype none
module tun_front #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire tun_pkg::tun_in_t                     in_data,
  output logic                                      dn_valid,
  input  wire logic                                 dn_stall,
  output logic [tun_pkg::tun_iw(FRAC_BITS)-1:0]     dn_data
);
  import tun_pkg::*;

  localparam int DW = tun_dw(FRAC_BITS);

  typedef struct packed {
    logic signed [DW-1:0]  r;
    logic signed [DW-1:0]  p;
    logic [FRAC_BITS:0]    q;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     ln;
    logic [SW-1:0]   s;
    logic            zero;
  } it_t;

  logic [4:0] v_r;
  logic [4:0] en;

  always_comb begin
    en[4] = !v_r[4] || !dn_stall;
    for (int i = 3; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign dn_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < 5; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage A: edge vectors and the six products of the cross product
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0] pa_nxt [6];
  logic signed [PW-1:0] pa_r   [6];

  always_comb begin
    e1x = EW'(in_data.a_x) - EW'(in_data.b_x);
    e1y = EW'(in_data.a_y) - EW'(in_data.b_y);
    e1z = EW'(in_data.a_z) - EW'(in_data.b_z);
    e2x = EW'(in_data.b_x) - EW'(in_data.c_x);
    e2y = EW'(in_data.b_y) - EW'(in_data.c_y);
    e2z = EW'(in_data.b_z) - EW'(in_data.c_z);
    pa_nxt[0] = PW'(e1y) * PW'(e2z);
    pa_nxt[1] = PW'(e1z) * PW'(e2y);
    pa_nxt[2] = PW'(e1z) * PW'(e2x);
    pa_nxt[3] = PW'(e1x) * PW'(e2z);
    pa_nxt[4] = PW'(e1x) * PW'(e2y);
    pa_nxt[5] = PW'(e1y) * PW'(e2x);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r <= pa_nxt;
    end
  end

  // Stage B: cross product, split into magnitude and sign
  logic signed [NW-1:0] n_c   [3];
  logic [NW-1:0]        abs_c [3];
  logic [MW-1:0]        mag_nxt [3];
  logic [MW-1:0]        mag_r   [3];
  logic [2:0]           neg_b_nxt, neg_b_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i]       = NW'(pa_r[2*i]) - NW'(pa_r[2*i+1]);
      abs_c[i]     = n_c[i][NW-1] ? NW'(-n_c[i]) : NW'(n_c[i]);
      mag_nxt[i]   = abs_c[i][MW-1:0];
      neg_b_nxt[i] = n_c[i][NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mag_r   <= mag_nxt;
      neg_b_r <= neg_b_nxt;
    end
  end

  // Stage C: half-width partial products of the square
  logic [2*HW-1:0] hh_nxt [3], hl_nxt [3], ll_nxt [3];
  logic [2*HW-1:0] hh_r   [3], hl_r   [3], ll_r   [3];
  logic [2:0]      neg_c_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh_nxt[i] = (2*HW)'(mag_r[i][MW-1:HW]) * (2*HW)'(mag_r[i][MW-1:HW]);
      hl_nxt[i] = (2*HW)'(mag_r[i][MW-1:HW]) * (2*HW)'(mag_r[i][HW-1:0]);
      ll_nxt[i] = (2*HW)'(mag_r[i][HW-1:0])  * (2*HW)'(mag_r[i][HW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hh_r    <= hh_nxt;
      hl_r    <= hl_nxt;
      ll_r    <= ll_nxt;
      neg_c_r <= neg_b_r;
    end
  end

  // Stage D: squares
  logic [SQW-1:0] sq_nxt [3];
  logic [SQW-1:0] sq_r   [3];
  logic [2:0]     neg_d_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SQW'(hh_r[i]) << (2*HW)) + (SQW'(hl_r[i]) << (HW+1)) + SQW'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sq_r    <= sq_nxt;
      neg_d_r <= neg_c_r;
    end
  end

  // Stage E: squared length and the starting residuals of the root search
  logic [SW-1:0] s_c;
  it_t           it_nxt, it_r;

  always_comb begin
    s_c         = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    it_nxt.s    = s_c;
    it_nxt.zero = (s_c == '0);
    for (int i = 0; i < 3; i++) begin
      it_nxt.ln[i].r   = $signed(DW'(sq_r[i]) << (2*FRAC_BITS+2)) - $signed(DW'(s_c));
      it_nxt.ln[i].p   = -$signed(DW'(s_c));
      it_nxt.ln[i].q   = '0;
      it_nxt.ln[i].neg = neg_d_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      it_r <= it_nxt;
    end
  end

  assign dn_data = it_r;

endmodule
`default_nettype wire

>>> design/tun_root_step.sv
`default_nettype none
module tun_root_step #(
  parameter int FRAC_BITS = 14,
  parameter int K         = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 up_valid,
  output logic                                      up_stall,
  input  wire logic [tun_pkg::tun_iw(FRAC_BITS)-1:0] up_data,
  output logic                                      dn_valid,
  input  wire logic                                 dn_stall,
  output logic [tun_pkg::tun_iw(FRAC_BITS)-1:0]     dn_data
);
  import tun_pkg::*;

  localparam int DW = tun_dw(FRAC_BITS);

  typedef struct packed {
    logic signed [DW-1:0]  r;
    logic signed [DW-1:0]  p;
    logic [FRAC_BITS:0]    q;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     ln;
    logic [SW-1:0]   s;
    logic            zero;
  } it_t;

  it_t                  cur, it_nxt, it_r;
  logic signed [DW-1:0] delta [3];
  logic signed [DW-1:0] s_w;
  logic                 skip;
  logic                 take;
  logic                 v_r;
  logic                 en;

  // Trial bit K: (2t-1)^2 S grows by 2^(K+2) P + 2^(2K+2) S, where P = (2q-1) S.
  always_comb begin
    cur    = it_t'(up_data);
    it_nxt = cur;
    s_w    = $signed(DW'(cur.s));
    for (int i = 0; i < 3; i++) begin
      skip     = (K < FRAC_BITS) && cur.ln[i].q[FRAC_BITS];
      delta[i] = (cur.ln[i].p <<< (K+2)) + (s_w <<< (2*K+2));
      take     = !skip && (delta[i] <= cur.ln[i].r);
      if (take) begin
        it_nxt.ln[i].r = cur.ln[i].r - delta[i];
        it_nxt.ln[i].p = cur.ln[i].p + (s_w <<< (K+1));
        it_nxt.ln[i].q = cur.ln[i].q | ((FRAC_BITS+1)'(1) << K);
      end
    end
  end

  assign en       = !v_r || !dn_stall;
  assign up_stall = !en;
  assign dn_valid = v_r;
  assign dn_data  = it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r <= it_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/triangle_unit_normal.sv
`default_nettype none
// Unit face normal of a triangle in signed fixed point.
// Input channel: in_valid / in_stall / in_data carries three vertices a, b, c.
// Output channel: out_valid / out_stall / out_data carries norm_x, norm_y,
// norm_z with FRAC_BITS fraction bits, rounded to nearest, and a degenerate
// flag that is set (with a zero vector) when the cross product is zero.
// One result per triangle, in order.
// Pipeline: five front stages (edges and products, cross product, partial
// squares, squares, squared length) then one root step per result bit and
// the output register.
// Throughput: one triangle per cycle while out_stall is low; every stage
// has its own valid bit.
// Stall: out_stall holds the output register; the stall moves back stage by
// stage only through full stages, so bubbles are squeezed out before
// in_stall rises.
// Reset: synchronous rst_n clears all valid bits; nothing else is held.
module triangle_unit_normal #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tun_pkg::tun_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tun_pkg::tun_out_t      out_data
);
  import tun_pkg::*;

  localparam int DW    = tun_dw(FRAC_BITS);
  localparam int IW    = tun_iw(FRAC_BITS);
  localparam int STEPS = FRAC_BITS + 1;

  typedef struct packed {
    logic signed [DW-1:0]  r;
    logic signed [DW-1:0]  p;
    logic [FRAC_BITS:0]    q;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     ln;
    logic [SW-1:0]   s;
    logic            zero;
  } it_t;

  logic [IW-1:0]  ch_data  [STEPS+1];
  logic           ch_valid [STEPS+1];
  logic           ch_stall [STEPS+1];

  tun_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .dn_valid (ch_valid[0]),
    .dn_stall (ch_stall[0]),
    .dn_data  (ch_data[0])
  );

  for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
    tun_root_step #(.FRAC_BITS(FRAC_BITS), .K(FRAC_BITS - gi)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[gi]),
      .up_stall (ch_stall[gi]),
      .up_data  (ch_data[gi]),
      .dn_valid (ch_valid[gi+1]),
      .dn_stall (ch_stall[gi+1]),
      .dn_data  (ch_data[gi+1])
    );
  end

  // Output register
  it_t                    last;
  logic [FRAC_BITS+OW:0]  qe   [3];
  logic [OW-1:0]          comp [3];
  tun_out_t               out_nxt, out_r;
  logic                   out_valid_r;
  logic                   en_out;

  always_comb begin
    last = it_t'(ch_data[STEPS]);
    for (int i = 0; i < 3; i++) begin
      qe[i]   = (FRAC_BITS+OW+1)'(last.ln[i].q);
      comp[i] = last.ln[i].neg ? OW'(-qe[i][OW-1:0]) : qe[i][OW-1:0];
      if (last.zero) begin
        comp[i] = '0;
      end
    end
    out_nxt.norm_x     = comp[0];
    out_nxt.norm_y     = comp[1];
    out_nxt.norm_z     = comp[2];
    out_nxt.degenerate = last.zero;
  end

  assign en_out          = !out_valid_r || !out_stall;
  assign ch_stall[STEPS] = !en_out;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= ch_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tun_check.sv
`default_nettype none
`include "triangle_unit_normal_defines.svh"
module tun_check (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire tun_pkg::tun_out_t out_data
);

  // a held result stays put until its transfer
  `TUN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed while stalled")

  // degenerate triangle gives the zero vector
  `TUN_ASSERT_SAME(a_degen_zero, out_valid && out_data.degenerate, out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0, "degenerate with nonzero normal")

  // an empty output register lets the whole pipe move
  `TUN_ASSERT_SAME(a_no_false_stall, !out_valid, !in_stall, "input stalled with empty output")

  // nothing comes out in the cycle after reset
  `TUN_ASSERT_SAME(a_reset_empty, $past(!rst_n), !out_valid, "output valid straight after reset")

endmodule

bind triangle_unit_normal tun_check u_tun_check (.*);
`default_nettype wire

>>> tb/triangle_unit_normal_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal_tb;
  import tun_pkg::*;

  localparam int FRAC = 14;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tun_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tun_out_t out_data;

  tun_out_t normal_q[$];
  int       err_cnt;
  bit       rx_stall_en;

  triangle_unit_normal #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // round(mag * 2^FRAC / sqrt(len2)), ties away from zero, by comparing squares
  function automatic logic signed [OW-1:0] scale_comp(input longint comp,
                                                      input logic [127:0] len2);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] q;
    logic [127:0] t;
    logic [127:0] odd;
    logic [127:0] q_s;
    mag = comp < 0 ? -comp : comp;
    rhs = (mag << (FRAC + 1)) * (mag << (FRAC + 1));
    q = 0;
    for (int k = FRAC; k >= 0; k--) begin
      t = q | (128'd1 << k);
      if (t <= (128'd1 << FRAC)) begin
        odd = 2 * t - 1;
        if (odd * odd * len2 <= rhs) q = t;
      end
    end
    q_s = comp < 0 ? -q : q;
    return q_s[OW-1:0];
  endfunction

  function automatic tun_out_t face_normal(input tun_in_t v);
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    longint nx, ny, nz;
    logic signed [127:0] wx, wy, wz;
    logic [127:0] len2;
    tun_out_t r;
    e1x = longint'(v.a_x) - longint'(v.b_x);
    e1y = longint'(v.a_y) - longint'(v.b_y);
    e1z = longint'(v.a_z) - longint'(v.b_z);
    e2x = longint'(v.b_x) - longint'(v.c_x);
    e2y = longint'(v.b_y) - longint'(v.c_y);
    e2z = longint'(v.b_z) - longint'(v.c_z);
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    r = '0;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // squares need more than 64 bits
    wx = nx;
    wy = ny;
    wz = nz;
    len2 = wx * wx + wy * wy + wz * wz;
    r.norm_x = scale_comp(nx, len2);
    r.norm_y = scale_comp(ny, len2);
    r.norm_z = scale_comp(nz, len2);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // in_valid stays high into the next item when it follows with no gap
  task automatic send_triangle(input tun_in_t v, input bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 9) : 0;
    if ($urandom_range(0, 3) == 0) idle = 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    normal_q.push_back(face_normal(v));
    do @(posedge clk); while (in_stall);
  endtask

  // stall pattern: a random hold-off before each result while rx_stall_en is set
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = rx_stall_en ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    tun_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (normal_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = normal_q.pop_front();
        if (out_data.norm_x !== want.norm_x)
          report_mismatch("norm_x", out_data.norm_x, want.norm_x);
        if (out_data.norm_y !== want.norm_y)
          report_mismatch("norm_y", out_data.norm_y, want.norm_y);
        if (out_data.norm_z !== want.norm_z)
          report_mismatch("norm_z", out_data.norm_z, want.norm_z);
        if (out_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_data.degenerate, want.degenerate);
      end
    end
  end

  function automatic tun_in_t tri_of(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    tun_in_t v;
    v.a_x = COORD_W'(ax); v.a_y = COORD_W'(ay); v.a_z = COORD_W'(az);
    v.b_x = COORD_W'(bx); v.b_y = COORD_W'(by); v.b_z = COORD_W'(bz);
    v.c_x = COORD_W'(cx); v.c_y = COORD_W'(cy); v.c_z = COORD_W'(cz);
    return v;
  endfunction

  task automatic test_directed();
    send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_triangle(tri_of(1, 0, 0, 0, 0, 0, 0, 1, 0), 0);
    send_triangle(tri_of(0, 1, 0, 0, 0, 0, 0, 0, 1), 0);
    send_triangle(tri_of(0, 0, 1, 0, 0, 0, 1, 0, 0), 0);
    send_triangle(tri_of(0, 1, 0, 0, 0, 0, 1, 0, 0), 0);
    send_triangle(tri_of(1, 1, 1, 2, 2, 2, 3, 3, 3), 0);           // collinear
    send_triangle(tri_of(5, -7, 9, 5, -7, 9, 100, 3, -2), 0);      // repeated vertex
    send_triangle(tri_of(32767, 32767, 32767, -32768, -32768, -32768,
                         32767, -32768, 32767), 0);
    send_triangle(tri_of(-32768, 32767, -32768, 32767, -32768, 32767,
                         -32768, -32768, 32767), 0);
    send_triangle(tri_of(32767, -32768, 0, -32768, 0, 32767, 0, 32767, -32768), 0);
    send_triangle(tri_of(-32768, -32768, -32768, 32767, 32767, 32767,
                         -32768, 32767, -32768), 0);
    send_triangle(tri_of(1, 1, 0, 0, 0, 0, 2, 1, 0), 0);
    send_triangle(tri_of(3, 4, 0, 0, 0, 0, 0, 0, 5), 0);
    send_triangle(tri_of(1, 2, 3, 0, 0, 0, -3, 5, 7), 0);
    send_triangle(tri_of(-1, -1, -1, 0, 0, 0, 1, -1, 1), 0);
    send_triangle(tri_of(32767, 0, 0, 0, 0, 0, 0, 0, 1), 0);
  endtask

  task automatic test_random(input int count);
    tun_in_t      v;
    int           mode;
    logic [159:0] raw;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
      v    = raw[$bits(tun_in_t)-1:0];
      if (mode == 0) begin
        // small coordinates: near-degenerate and tie cases
        v = tri_of($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                   $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                   $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                   $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                   $urandom_range(0, 6) - 3);
      end else if (mode == 1) begin
        v.c_x = COORD_W'(2 * v.b_x - v.a_x);   // c = 2b - a: collinear unless it wraps or b_x is then moved
        v.c_y = COORD_W'(2 * v.b_y - v.a_y);
        v.c_z = COORD_W'(2 * v.b_z - v.a_z);
        if ($urandom_range(0, 1)) v.b_x = v.a_x;
      end else if (mode == 2) begin
        v.a_z = v.b_z;               // flat in z
        v.c_z = v.b_z;
      end
      send_triangle(v, 1);
    end
  endtask

  initial begin
    int guard;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    err_cnt     = 0;
    rx_stall_en = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    rx_stall_en = 1'b1;
    test_random(340);
    rx_stall_en = 1'b0;
    test_random(340);
    in_valid <= 1'b0;
    rx_stall_en = 1'b1;

    guard = 0;
    while (normal_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (FRAC + 20) @(posedge clk);
    if (err_cnt == 0 && normal_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/tun_pkg.sv
design/tun_front.sv
design/tun_root_step.sv
design/triangle_unit_normal.sv
design/tun_check.sv
tb/triangle_unit_normal_tb.sv
